>>> design/assert_macros.svh
// assertion helpers for the checker file gcc_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define GCC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the usual clk_i / rst_ni pair
`define GCC_ASSERT(lbl, prop, msg) `GCC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> design/gcc_pkg.sv
// types, constants and helpers of the grid coverage counter
// used by gcc_div, grid_coverage_counter and gcc_checker; no dependencies
package gcc_pkg;

  localparam int MAX_SIDE  = 256;
  localparam int REG_W     = 9;
  localparam int LIMIT_W   = 16;
  localparam int COORD_W   = 16;
  localparam int DENS_W    = 16;
  localparam int OUT_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int RATIO_W   = FRAC_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int POS_W   = $clog2(MAX_SIDE);
  localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int STEP_W  = $clog2(RATIO_W + 1);

  // generation tags kept next to each map entry
  localparam int EPOCH_W = 6;
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = EPOCH_W'((2 ** EPOCH_W) - 1);

  localparam logic [REG_W-1:0]   WIDTH_RST  = REG_W'(256);
  localparam logic [REG_W-1:0]   HEIGHT_RST = REG_W'(256);
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(32768);

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_LIMIT = CFG_IDX_W'(2);

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(2 ** FRAC_W);

  typedef enum logic [1:0] {
    OP_SET_DENSITY = 2'd0,
    OP_VISIT       = 2'd1,
    OP_CLEAR_VISITS = 2'd2,
    OP_RESET_ALL   = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]                 op;
    logic signed [COORD_W-1:0]  cell_x;
    logic signed [COORD_W-1:0]  cell_y;
    logic [DENS_W-1:0]          density;
  } gcc_in_t;

  typedef struct packed {
    logic [OUT_W-1:0]   cell_count;
    logic [OUT_W-1:0]   visited_count;
    logic [OUT_W-1:0]   sparse_count;
    logic [OUT_W-1:0]   visited_sparse_count;
    logic [RATIO_W-1:0] coverage_ratio;
    logic [RATIO_W-1:0] sparse_ratio;
    logic               in_range;
  } gcc_out_t;

  typedef struct packed {
    logic               mark;
    logic [EPOCH_W-1:0] tag;
  } sparse_ent_t;

  // register value above MAX_SIDE is used as MAX_SIDE
  function automatic logic [SIDE_W-1:0] side_of(input logic [REG_W-1:0] r);
    logic [SIDE_W-1:0] s;
    if (int'(r) > MAX_SIDE) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = SIDE_W'(r);
    end
    return s;
  endfunction

endpackage

>>> design/gcc_div.sv
// shift-subtract divider: floor(num * 2^16 / den), one quotient bit a cycle
// uses gcc_pkg; needs num <= den, gives 0 when den is 0
module gcc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gcc_pkg::CNT_W-1:0]   num_i,
  input  logic [gcc_pkg::CNT_W-1:0]   den_i,
  output logic                        done_o,
  output logic [gcc_pkg::RATIO_W-1:0] quo_o
);
  import gcc_pkg::*;

  logic                busy_q;
  logic [STEP_W-1:0]   step_q;
  logic [CNT_W:0]      rem_q;
  logic [CNT_W-1:0]    den_q;
  logic [RATIO_W-1:0]  quo_q;
  logic                zero_q;
  logic [CNT_W:0]      trial;
  logic                fits;

  // the top quotient bit compares num itself, later bits shift first
  assign trial = (step_q == STEP_W'(RATIO_W)) ? rem_q : {rem_q[CNT_W-1:0], 1'b0};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(RATIO_W);
    end else if (busy_q) begin
      step_q <= step_q - STEP_W'(1);
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quo_q  <= '0;
      zero_q <= den_i == '0;
    end else if (busy_q) begin
      rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
      quo_q <= {quo_q[RATIO_W-2:0], fits};
    end
  end

  assign done_o = !busy_q;
  assign quo_o  = zero_q ? '0 : quo_q;

endmodule

>>> design/grid_coverage_counter.sv
// Grid coverage counter: visited and sparse bit maps over a grid, with totals
// and two coverage ratios in unsigned fixed point (16 fraction bits).
//
// Usage:
//  - input channel in_valid_i/in_ready_o carries one item (op, cell, density);
//    every item returns exactly one result on out_valid_o/out_ready_i
//  - configuration: cfg_we_i writes register cfg_idx_i (0 width, 1 height,
//    2 density limit); a size write erases maps and totals;
//    write only while no item is in flight
//  - an item steps through the states read (map read), modify (update) and
//    divider start, then waits while the shift-subtract dividers run and
//    until the output is free; the output load returns to idle, and only
//    there is a new item taken
//  - the result sits in an output register; the next item is taken while it
//    waits, and its own result holds in the divider until the output is free
//  - both maps live in synchronous memories tagged with generation counters,
//    so clear and reset ops finish at once; every 63rd erase of a map, and
//    reset, starts a sweep over all 65536 entries (MAX_SIDE squared) of that
//    map during which in_ready_o stays low
//  - after reset: width 256, height 256, limit 32768, all counts zero
// Depends on gcc_pkg and gcc_div.
module grid_coverage_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  gcc_pkg::gcc_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output gcc_pkg::gcc_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [gcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gcc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import gcc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE      = 5'b00001,
    S_READ      = 5'b00010,
    S_MODIFY    = 5'b00100,
    S_DIV_START = 5'b01000,
    S_DIV_WAIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [REG_W-1:0]   width_q, height_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               size_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      limit_q  <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_WIDTH:    width_q  <= cfg_wdata_i[REG_W-1:0];
        CFG_GRID_HEIGHT:   height_q <= cfg_wdata_i[REG_W-1:0];
        CFG_DENSITY_LIMIT: limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign size_wr = cfg_we_i && (cfg_idx_i == CFG_GRID_WIDTH || cfg_idx_i == CFG_GRID_HEIGHT);

  logic [SIDE_W-1:0] w_side, h_side;
  logic [CNT_W-1:0]  cells;

  assign w_side = side_of(width_q);
  assign h_side = side_of(height_q);
  assign cells  = CNT_W'(CNT_W'(w_side) * CNT_W'(h_side));

  // item capture
  logic              in_xfer;
  logic [COORD_W-1:0] x_raw, y_raw;
  logic              in_grid;
  logic [ADDR_W-1:0] addr;
  op_e               op_q;
  logic              inside_q;
  logic              sparse_now_q;
  logic [ADDR_W-1:0] addr_q;
  logic              vclr_q, sclr_q;

  assign in_ready_o = (state_q == S_IDLE) && !vclr_q && !sclr_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign x_raw  = $unsigned(in_data_i.cell_x);
  assign y_raw  = $unsigned(in_data_i.cell_y);
  // negative coordinates read as large unsigned values and fall outside
  assign in_grid = (op_e'(in_data_i.op) == OP_SET_DENSITY || op_e'(in_data_i.op) == OP_VISIT)
                   && (x_raw < COORD_W'(w_side)) && (y_raw < COORD_W'(h_side));
  assign addr   = ADDR_W'(ADDR_W'(y_raw[POS_W-1:0]) * ADDR_W'(MAX_SIDE))
                  + ADDR_W'(x_raw[POS_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q         <= op_e'(in_data_i.op);
      inside_q     <= in_grid;
      sparse_now_q <= in_data_i.density < limit_q;
      addr_q       <= addr;
    end
  end

  // bit maps with generation tags
  logic [EPOCH_W-1:0] vmem [DEPTH];
  sparse_ent_t        smem [DEPTH];
  logic [EPOCH_W-1:0] vrd_q;
  sparse_ent_t        srd_q;
  logic [EPOCH_W-1:0] vepoch_q, sepoch_q;
  logic [ADDR_W-1:0]  vclr_addr_q, sclr_addr_q;
  logic               v_wr, s_wr;
  logic               vis_hit, spa_hit;
  logic               v_erase, s_erase;
  logic               in_modify;

  assign in_modify = state_q == S_MODIFY;
  assign vis_hit   = vrd_q == vepoch_q;
  assign spa_hit   = srd_q.mark && (srd_q.tag == sepoch_q);
  assign v_wr      = in_modify && inside_q && op_q == OP_VISIT;
  assign s_wr      = in_modify && inside_q && op_q == OP_SET_DENSITY;
  assign s_erase   = (in_modify && op_q == OP_RESET_ALL) || size_wr;
  assign v_erase   = (in_modify && op_q == OP_CLEAR_VISITS) || s_erase;

  always_ff @(posedge clk_i) begin
    if (vclr_q) begin
      vmem[vclr_addr_q] <= '0;
    end else if (v_wr) begin
      vmem[addr_q] <= vepoch_q;
    end
    if (state_q == S_READ) begin
      vrd_q <= vmem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sclr_q) begin
      smem[sclr_addr_q] <= '0;
    end else if (s_wr) begin
      smem[addr_q] <= '{mark: sparse_now_q, tag: sepoch_q};
    end
    if (state_q == S_READ) begin
      srd_q <= smem[addr_q];
    end
  end

  // erase bumps the tag; when tags run out the map is swept back to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vepoch_q    <= EPOCH_ONE;
      vclr_q      <= 1'b1;
      vclr_addr_q <= '0;
    end else if (vclr_q) begin
      vclr_addr_q <= vclr_addr_q + ADDR_W'(1);
      if (vclr_addr_q == ADDR_W'(DEPTH - 1)) begin
        vclr_q <= 1'b0;
      end
    end else if (v_erase) begin
      if (vepoch_q == EPOCH_MAX) begin
        vepoch_q    <= EPOCH_ONE;
        vclr_q      <= 1'b1;
        vclr_addr_q <= '0;
      end else begin
        vepoch_q <= vepoch_q + EPOCH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sepoch_q    <= EPOCH_ONE;
      sclr_q      <= 1'b1;
      sclr_addr_q <= '0;
    end else if (sclr_q) begin
      sclr_addr_q <= sclr_addr_q + ADDR_W'(1);
      if (sclr_addr_q == ADDR_W'(DEPTH - 1)) begin
        sclr_q <= 1'b0;
      end
    end else if (s_erase) begin
      if (sepoch_q == EPOCH_MAX) begin
        sepoch_q    <= EPOCH_ONE;
        sclr_q      <= 1'b1;
        sclr_addr_q <= '0;
      end else begin
        sepoch_q <= sepoch_q + EPOCH_W'(1);
      end
    end
  end

  // running totals
  logic [CNT_W-1:0] visited_q, sparse_q, vs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      sparse_q  <= '0;
      vs_q      <= '0;
    end else if (v_erase) begin
      visited_q <= '0;
      vs_q      <= '0;
      if (s_erase) begin
        sparse_q <= '0;
      end
    end else if (s_wr && (sparse_now_q != spa_hit)) begin
      if (sparse_now_q) begin
        sparse_q <= sparse_q + CNT_W'(1);
        if (vis_hit) begin
          vs_q <= vs_q + CNT_W'(1);
        end
      end else begin
        sparse_q <= sparse_q - CNT_W'(1);
        if (vis_hit) begin
          vs_q <= vs_q - CNT_W'(1);
        end
      end
    end else if (v_wr && !vis_hit) begin
      visited_q <= visited_q + CNT_W'(1);
      if (spa_hit) begin
        vs_q <= vs_q + CNT_W'(1);
      end
    end
  end

  // ratios
  logic               div_start;
  logic               cov_done, spr_done;
  logic [RATIO_W-1:0] cov_quo, spr_quo;

  assign div_start = state_q == S_DIV_START;

  gcc_div u_cov_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (visited_q),
    .den_i   (cells),
    .done_o  (cov_done),
    .quo_o   (cov_quo)
  );

  gcc_div u_spr_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (vs_q),
    .den_i   (sparse_q),
    .done_o  (spr_done),
    .quo_o   (spr_quo)
  );

  // sequencing and output register
  logic     out_load;
  logic     out_valid_q;
  gcc_out_t out_q;

  assign out_load = (state_q == S_DIV_WAIT) && cov_done && spr_done
                    && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_xfer) state_d = S_READ;
      S_READ:      state_d = S_MODIFY;
      S_MODIFY:    state_d = S_DIV_START;
      S_DIV_START: state_d = S_DIV_WAIT;
      S_DIV_WAIT:  if (out_load) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.cell_count           <= OUT_W'(cells);
      out_q.visited_count        <= OUT_W'(visited_q);
      out_q.sparse_count         <= OUT_W'(sparse_q);
      out_q.visited_sparse_count <= OUT_W'(vs_q);
      out_q.coverage_ratio       <= cov_quo;
      out_q.sparse_ratio         <= spr_quo;
      out_q.in_range             <= inside_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> design/gcc_checker.sv
// port-level checks of the grid coverage counter, bound to the top level
// uses gcc_pkg and assert_macros.svh
`include "assert_macros.svh"

module gcc_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input gcc_pkg::gcc_out_t out_data_o
);
  import gcc_pkg::*;

  `GCC_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `GCC_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o), "result changed while stalled")
  `GCC_ASSERT(a_ratio_max, out_valid_o |-> (out_data_o.coverage_ratio <= RATIO_ONE && out_data_o.sparse_ratio <= RATIO_ONE), "ratio above one")
  `GCC_ASSERT(a_full_sparse, out_valid_o && out_data_o.sparse_ratio == RATIO_ONE |-> out_data_o.visited_sparse_count == out_data_o.sparse_count, "full sparse ratio with unvisited sparse cells")

endmodule

bind grid_coverage_counter gcc_checker u_gcc_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// testbench of grid_coverage_counter: directed and random items, checked
// against a scoreboard that keeps its own visited and sparse maps
// depends on gcc_pkg and the design files
module tb_top;
  import gcc_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 500000;
  localparam int unsigned TAIL_CYCLES = 60;
  // no register behind this index, a write to it is dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(3);

  class coverage_scoreboard;
    bit visited_map [DEPTH];
    bit sparse_map [DEPTH];
    int unsigned visited_total;
    int unsigned sparse_total;
    int unsigned visited_sparse_total;
    logic [REG_W-1:0] width_reg;
    logic [REG_W-1:0] height_reg;
    logic [LIMIT_W-1:0] limit_reg;
    gcc_out_t pending_results [$];
    int unsigned error_count;

    function new();
      width_reg = WIDTH_RST;
      height_reg = HEIGHT_RST;
      limit_reg = LIMIT_RST;
      error_count = 0;
      erase_maps(1'b0);
    endfunction

    function void erase_maps(bit keep_sparse);
      foreach (visited_map[i]) visited_map[i] = 1'b0;
      visited_total = 0;
      visited_sparse_total = 0;
      if (!keep_sparse) begin
        foreach (sparse_map[i]) sparse_map[i] = 1'b0;
        sparse_total = 0;
      end
    endfunction

    function int unsigned clamp_side(logic [REG_W-1:0] r);
      return (r > MAX_SIDE) ? MAX_SIDE : int'(r);
    endfunction

    function logic [RATIO_W-1:0] fixed_ratio(int unsigned num, int unsigned den);
      longint unsigned q;
      if (den == 0) return '0;
      q = longint'(num);
      q = (q << FRAC_W) / den;
      return RATIO_W'(q);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH: begin
          width_reg = data[REG_W-1:0];
          erase_maps(1'b0);
        end
        CFG_GRID_HEIGHT: begin
          height_reg = data[REG_W-1:0];
          erase_maps(1'b0);
        end
        CFG_DENSITY_LIMIT: begin
          limit_reg = data[LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_item(gcc_in_t item);
      gcc_out_t want;
      logic [COORD_W-1:0] ux;
      logic [COORD_W-1:0] uy;
      int unsigned w;
      int unsigned h;
      int unsigned addr;
      bit in_grid;
      bit now_sparse;
      op_e op;
      ux = item.cell_x;
      uy = item.cell_y;
      op = op_e'(item.op);
      w = clamp_side(width_reg);
      h = clamp_side(height_reg);
      in_grid = (op == OP_SET_DENSITY || op == OP_VISIT) && ux < w && uy < h;
      addr = int'(uy) * MAX_SIDE + int'(ux);
      case (op)
        OP_SET_DENSITY: begin
          if (in_grid) begin
            now_sparse = item.density < limit_reg;
            if (now_sparse != sparse_map[addr]) begin
              if (now_sparse) begin
                sparse_total++;
                if (visited_map[addr]) visited_sparse_total++;
              end else begin
                sparse_total--;
                if (visited_map[addr]) visited_sparse_total--;
              end
              sparse_map[addr] = now_sparse;
            end
          end
        end
        OP_VISIT: begin
          if (in_grid && !visited_map[addr]) begin
            visited_map[addr] = 1'b1;
            visited_total++;
            if (sparse_map[addr]) visited_sparse_total++;
          end
        end
        OP_CLEAR_VISITS: erase_maps(1'b1);
        OP_RESET_ALL: erase_maps(1'b0);
      endcase
      want.cell_count = OUT_W'(w * h);
      want.visited_count = OUT_W'(visited_total);
      want.sparse_count = OUT_W'(sparse_total);
      want.visited_sparse_count = OUT_W'(visited_sparse_total);
      want.coverage_ratio = fixed_ratio(visited_total, w * h);
      want.sparse_ratio = fixed_ratio(visited_sparse_total, sparse_total);
      want.in_range = in_grid;
      pending_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [OUT_W-1:0] want,
                                logic [OUT_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(gcc_out_t got);
      gcc_out_t want;
      if (pending_results.size() == 0) begin
        $error("result transfer with no item pending: %p", got);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("cell_count", want.cell_count, got.cell_count);
      compare_field("visited_count", want.visited_count, got.visited_count);
      compare_field("sparse_count", want.sparse_count, got.sparse_count);
      compare_field("visited_sparse_count", want.visited_sparse_count,
                    got.visited_sparse_count);
      compare_field("coverage_ratio", want.coverage_ratio, got.coverage_ratio);
      compare_field("sparse_ratio", want.sparse_ratio, got.sparse_ratio);
      compare_field("in_range", want.in_range, got.in_range);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  gcc_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  gcc_out_t out_data_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  coverage_scoreboard sb;
  bit no_gaps;
  int unsigned quiet_cycles = 0;

  grid_coverage_counter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 13);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int unsigned side);
    int unsigned r;
    r = $urandom_range(99);
    if (side > 0 && r < 88) return COORD_W'($urandom_range(side - 1));
    if (r < 92) return COORD_W'(side + $urandom_range(3));
    if (r < 96) return COORD_W'(-int'($urandom_range(4, 1)));
    return COORD_W'($urandom());
  endfunction

  // densities around the limit so that marks flip both ways
  function automatic logic [DENS_W-1:0] pick_density();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return DENS_W'(sb.limit_reg - 1'b1);
    if (r < 50) return sb.limit_reg;
    if (r < 60) return '0;
    if (r < 70) return '1;
    return DENS_W'($urandom());
  endfunction

  function automatic gcc_in_t make_item(op_e op, int x, int y, int d);
    gcc_in_t item;
    item.op = op;
    item.cell_x = COORD_W'(x);
    item.cell_y = COORD_W'(y);
    item.density = DENS_W'(d);
    return item;
  endfunction

  // valid stays high across back-to-back items, lowered only for a gap
  task automatic send_item(input gcc_in_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(item);
  endtask

  task automatic drain();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper bits of a size write are random and must be dropped
  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned lim);
    logic [CFG_DATA_W-1:0] d;
    drain();
    d = $urandom();
    d[REG_W-1:0] = REG_W'(w);
    write_reg(CFG_GRID_WIDTH, d);
    d = $urandom();
    d[REG_W-1:0] = REG_W'(h);
    write_reg(CFG_GRID_HEIGHT, d);
    write_reg(CFG_DENSITY_LIMIT, CFG_DATA_W'(lim));
  endtask

  task automatic run_random(input int unsigned n);
    gcc_in_t item;
    int unsigned r;
    int unsigned w;
    int unsigned h;
    w = sb.clamp_side(sb.width_reg);
    h = sb.clamp_side(sb.height_reg);
    repeat (n) begin
      r = $urandom_range(999);
      if (r < 20) item.op = OP_CLEAR_VISITS;
      else if (r < 35) item.op = OP_RESET_ALL;
      else if (r < 450) item.op = OP_SET_DENSITY;
      else item.op = OP_VISIT;
      item.cell_x = pick_coord(w);
      item.cell_y = pick_coord(h);
      item.density = pick_density();
      send_item(item);
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $error("no transfer for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : out_ready_drive
    int unsigned stall;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    sb = new();
    no_gaps = 1'b0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset grid: 256 x 256, limit 32768
    send_item(make_item(OP_VISIT, 0, 0, 0));
    send_item(make_item(OP_VISIT, 0, 0, 0));          // repeat visit
    send_item(make_item(OP_SET_DENSITY, 0, 0, 0));     // sparse on a visited cell
    send_item(make_item(OP_SET_DENSITY, 0, 0, 32767)); // stays sparse
    send_item(make_item(OP_SET_DENSITY, 0, 0, 32768)); // equal to limit, not sparse
    send_item(make_item(OP_SET_DENSITY, 0, 0, 65535));
    send_item(make_item(OP_SET_DENSITY, 255, 255, 100));
    send_item(make_item(OP_VISIT, 255, 255, 65535));
    send_item(make_item(OP_VISIT, 256, 0, 0));
    send_item(make_item(OP_VISIT, 0, 256, 0));
    send_item(make_item(OP_VISIT, -1, 0, 0));
    send_item(make_item(OP_SET_DENSITY, 0, -32768, 0));
    send_item(make_item(OP_VISIT, 32767, 32767, 0));
    send_item(make_item(OP_SET_DENSITY, -32768, 32767, 0));
    send_item(make_item(OP_SET_DENSITY, 1, 0, 0));
    send_item(make_item(OP_CLEAR_VISITS, 1, 0, 0));    // coordinates not used
    send_item(make_item(OP_VISIT, 1, 0, 0));
    send_item(make_item(OP_VISIT, 255, 255, 0));
    send_item(make_item(OP_RESET_ALL, -1, -1, 65535));
    send_item(make_item(OP_SET_DENSITY, 5, 7, 0));
    send_item(make_item(OP_VISIT, 5, 7, 0));
    send_item(make_item(OP_CLEAR_VISITS, 0, 0, 0));
    in_valid_i <= 1'b0;

    configure(8, 8, 30000);
    run_random(220);
    // new limit only, stored marks stay
    drain();
    write_reg(CFG_DENSITY_LIMIT, CFG_DATA_W'(40000));
    no_gaps = 1'b1;
    run_random(150);
    no_gaps = 1'b0;
    configure(1, 1, 0);
    run_random(60);
    configure(256, 1, 65535);
    run_random(150);
    configure(1, 256, $urandom_range(65535));
    run_random(150);
    configure(0, 5, $urandom_range(65535));   // empty grid
    run_random(50);
    configure(300, 511, 32768);               // both sides clamp to full size
    run_random(100);
    drain();
    write_reg(CFG_UNUSED_IDX, '1);
    configure(16, 12, $urandom_range(65535));
    no_gaps = 1'b1;
    run_random(150);
    no_gaps = 1'b0;
    @(posedge clk_i);
    run_random(150);
    configure(3, 2, $urandom_range(65535));
    run_random(200);
    configure(256, 256, 32768);
    run_random(150);
    configure(10, 10, 65535);
    run_random(250);

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
